/* hw/rtl/shg_pkg.sv */
package shg_pkg;

  // defaults for the top level parameters
  localparam int unsigned MAX_DEGREE_DEF      = 4;
  localparam int unsigned COORD_FRAC_BITS_DEF = 14;

  // fixed arithmetic formats
  localparam int unsigned KFRAC    = 30;
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned NAXIS    = 4;   // harmonic, d/dx, d/dy, d/dz
  localparam int unsigned NTERM    = 6;
  localparam int unsigned NFACT    = 4;
  localparam int unsigned PROD_W   = 96;
  localparam int unsigned ACC_W    = 108;
  localparam int unsigned SH_W     = 7;

  // factor select codes
  localparam logic [1:0] FSEL_ONE = 2'd0;
  localparam logic [1:0] FSEL_X   = 2'd1;
  localparam logic [1:0] FSEL_Y   = 2'd2;
  localparam logic [1:0] FSEL_Z   = 2'd3;

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    logic [2:0]         degree;
    logic               cumulative;
  } shg_in_t;

  typedef struct packed {
    logic [2:0]         degree_out;
    logic signed [3:0]  order_m;
    logic signed [31:0] harmonic;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               last;
  } shg_out_t;

  // one (l, m) handed from the sequencer to the arithmetic pipeline
  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
    logic [2:0]         l;
    logic signed [3:0]  m;
    logic               last;
  } shg_issue_t;

  typedef struct packed {
    logic signed [5:0] c;
    logic [2:0]        ex;
    logic [2:0]        ey;
    logic [2:0]        ez;
  } shg_mono_t;

  typedef struct packed {
    logic [4:0]                 k;
    shg_mono_t [NTERM-1:0]      t;
  } shg_row_t;

  typedef struct packed {
    logic signed [6:0]          coef;
    logic [NFACT-1:0][1:0]      fsel;
  } shg_term_t;

  // normalisation constants, unsigned Q2.30
  localparam logic [31:0] KROM [17] = '{
    32'd302896976,  32'd524632952,  32'd1173114945, 32'd338649115,
    32'd586557472,  32'd633554480,  32'd3103770403, 32'd490749190,
    32'd400695036,  32'd1551885201, 32'd2687944016, 32'd1900663441,
    32'd1015947344, 32'd718383256,  32'd113586366,  32'd507973672,
    32'd671986004
  };

  function automatic shg_mono_t mk(int c, int ex, int ey, int ez);
    shg_mono_t r;
    r.c  = 6'(c);
    r.ex = 3'(ex);
    r.ey = 3'(ey);
    r.ez = 3'(ez);
    return r;
  endfunction

  // polynomial of row l*l + m + l: constant index and terms
  function automatic shg_row_t row_terms(logic [4:0] row);
    shg_row_t r;
    r = '0;
    case (row)
      5'd0:  begin r.k = 5'd0;  r.t[0] = mk(1, 0, 0, 0); end
      5'd1:  begin r.k = 5'd1;  r.t[0] = mk(1, 0, 1, 0); end
      5'd2:  begin r.k = 5'd1;  r.t[0] = mk(1, 0, 0, 1); end
      5'd3:  begin r.k = 5'd1;  r.t[0] = mk(1, 1, 0, 0); end
      5'd4:  begin r.k = 5'd2;  r.t[0] = mk(1, 1, 1, 0); end
      5'd5:  begin r.k = 5'd2;  r.t[0] = mk(1, 0, 1, 1); end
      5'd6:  begin
        r.k = 5'd3;
        r.t[0] = mk(2, 0, 0, 2); r.t[1] = mk(-1, 2, 0, 0); r.t[2] = mk(-1, 0, 2, 0);
      end
      5'd7:  begin r.k = 5'd2;  r.t[0] = mk(1, 1, 0, 1); end
      5'd8:  begin r.k = 5'd4;  r.t[0] = mk(1, 2, 0, 0); r.t[1] = mk(-1, 0, 2, 0); end
      5'd9:  begin r.k = 5'd5;  r.t[0] = mk(3, 2, 1, 0); r.t[1] = mk(-1, 0, 3, 0); end
      5'd10: begin r.k = 5'd6;  r.t[0] = mk(1, 1, 1, 1); end
      5'd11: begin
        r.k = 5'd7;
        r.t[0] = mk(4, 0, 1, 2); r.t[1] = mk(-1, 2, 1, 0); r.t[2] = mk(-1, 0, 3, 0);
      end
      5'd12: begin
        r.k = 5'd8;
        r.t[0] = mk(2, 0, 0, 3); r.t[1] = mk(-3, 2, 0, 1); r.t[2] = mk(-3, 0, 2, 1);
      end
      5'd13: begin
        r.k = 5'd7;
        r.t[0] = mk(4, 1, 0, 2); r.t[1] = mk(-1, 3, 0, 0); r.t[2] = mk(-1, 1, 2, 0);
      end
      5'd14: begin r.k = 5'd9;  r.t[0] = mk(1, 2, 0, 1); r.t[1] = mk(-1, 0, 2, 1); end
      5'd15: begin r.k = 5'd5;  r.t[0] = mk(1, 3, 0, 0); r.t[1] = mk(-3, 1, 2, 0); end
      5'd16: begin r.k = 5'd10; r.t[0] = mk(1, 3, 1, 0); r.t[1] = mk(-1, 1, 3, 0); end
      5'd17: begin r.k = 5'd11; r.t[0] = mk(3, 2, 1, 1); r.t[1] = mk(-1, 0, 3, 1); end
      5'd18: begin
        r.k = 5'd12;
        r.t[0] = mk(6, 1, 1, 2); r.t[1] = mk(-1, 3, 1, 0); r.t[2] = mk(-1, 1, 3, 0);
      end
      5'd19: begin
        r.k = 5'd13;
        r.t[0] = mk(4, 0, 1, 3); r.t[1] = mk(-3, 2, 1, 1); r.t[2] = mk(-3, 0, 3, 1);
      end
      5'd20: begin
        r.k = 5'd14;
        r.t[0] = mk(8, 0, 0, 4);  r.t[1] = mk(-24, 2, 0, 2); r.t[2] = mk(-24, 0, 2, 2);
        r.t[3] = mk(3, 4, 0, 0);  r.t[4] = mk(6, 2, 2, 0);   r.t[5] = mk(3, 0, 4, 0);
      end
      5'd21: begin
        r.k = 5'd13;
        r.t[0] = mk(4, 1, 0, 3); r.t[1] = mk(-3, 3, 0, 1); r.t[2] = mk(-3, 1, 2, 1);
      end
      5'd22: begin
        r.k = 5'd15;
        r.t[0] = mk(6, 2, 0, 2);  r.t[1] = mk(-6, 0, 2, 2);
        r.t[2] = mk(-1, 4, 0, 0); r.t[3] = mk(1, 0, 4, 0);
      end
      5'd23: begin r.k = 5'd11; r.t[0] = mk(1, 3, 0, 1); r.t[1] = mk(-3, 1, 2, 1); end
      5'd24: begin
        r.k = 5'd16;
        r.t[0] = mk(1, 4, 0, 0); r.t[1] = mk(-6, 2, 2, 0); r.t[2] = mk(1, 0, 4, 0);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // term of the harmonic (axis 0) or of its derivative along axis 1..3
  function automatic shg_term_t term_desc(shg_mono_t mono, int axis);
    shg_term_t d;
    int        e [3];
    int        c;
    int        k;
    e[0] = int'(mono.ex);
    e[1] = int'(mono.ey);
    e[2] = int'(mono.ez);
    c    = int'(mono.c);
    if (axis != 0) begin
      if (e[axis-1] == 0) begin
        c = 0;
      end else begin
        c = c * e[axis-1];
        e[axis-1] = e[axis-1] - 1;
      end
    end
    d.coef = 7'(c);
    d.fsel = '0;
    k = 0;
    for (int v = 0; v < 3; v++) begin
      for (int j = 0; j < 4; j++) begin
        if (j < e[v] && k < 4) begin
          d.fsel[k] = 2'(v + 1);
          k = k + 1;
        end
      end
    end
    return d;
  endfunction

  function automatic logic signed [15:0] pick(logic [1:0] code, shg_issue_t it);
    logic signed [15:0] f;
    case (code)
      FSEL_ONE: f = 16'sd1;
      FSEL_X:   f = it.x_coord;
      FSEL_Y:   f = it.y_coord;
      FSEL_Z:   f = it.z_coord;
      default:  f = 16'sd1;
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/solid_harmonics_with_gradient.sv */
// Real regular solid harmonics up to degree 4 with their x, y and z
// gradients. Each input item (a Q1.14 point and a degree l) produces 2l+1
// results in rising order m, or (l+1)^2 results covering degrees 0..l in
// cumulative mode; the final one carries last. Results leave at one per
// cycle while the output is not held; an item occupies the input until
// the sequencer that feeds a six-stage arithmetic pipeline has issued all
// its (l, m), one per cycle unless the pipeline stalls; the next item is
// taken in the cycle its predecessor's last (l, m) is issued. Outputs
// are Q15.16, rounded half up and saturated.
module solid_harmonics_with_gradient import shg_pkg::*; #(
  parameter int unsigned MAX_DEGREE      = MAX_DEGREE_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  shg_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output shg_out_t out_o
);

  typedef struct packed {
    logic [2:0]        l;
    logic signed [3:0] m;
    logic              last;
    logic [SH_W-1:0]   sh_h;
    logic [SH_W-1:0]   sh_g;
  } meta_t;

  logic       en;
  logic       issue_valid;
  shg_issue_t issue;
  logic       v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  meta_t      meta_d, m1_q, m2_q, m3_q, m4_q, m5_q;

  logic signed [31:0]       p01_d  [NAXIS][NTERM];
  logic signed [31:0]       p23_d  [NAXIS][NTERM];
  logic signed [6:0]        coef_d [NAXIS][NTERM];
  logic [31:0]              k_d;
  logic signed [31:0]       s1_p01_q  [NAXIS][NTERM];
  logic signed [31:0]       s1_p23_q  [NAXIS][NTERM];
  logic signed [6:0]        s1_coef_q [NAXIS][NTERM];
  logic [31:0]              s1_k_q;
  logic signed [63:0]       s2_pk_q   [NAXIS][NTERM];
  logic signed [31:0]       s2_p01_q  [NAXIS][NTERM];
  logic signed [6:0]        s2_coef_q [NAXIS][NTERM];
  logic signed [63:0]       s3_lo_q   [NAXIS][NTERM];
  logic signed [63:0]       s3_hi_q   [NAXIS][NTERM];
  logic signed [6:0]        s3_coef_q [NAXIS][NTERM];
  logic signed [ACC_W-1:0]  s4_term_q [NAXIS][NTERM];
  logic signed [ACC_W-1:0]  s5_acc_q  [NAXIS];
  logic signed [31:0]       res_d     [NAXIS];
  shg_out_t                 out_q;

  // the whole pipe moves unless the output register is held
  assign en = !v6_q || out_ready_i;

  shg_seq #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .issue_valid_o (issue_valid),
    .issue_take_i  (en),
    .issue_o       (issue)
  );

  // stage 1: term lookup and the two coordinate pair products
  always_comb begin
    shg_row_t  row;
    shg_term_t td;
    logic [4:0] ridx;
    logic [2:0] dg;
    ridx = 5'(int'(issue.l) * int'(issue.l) + int'(issue.m) + int'(issue.l));
    row  = row_terms(ridx);
    k_d  = KROM[row.k];
    for (int a = 0; a < NAXIS; a++) begin
      for (int t = 0; t < NTERM; t++) begin
        td = term_desc(row.t[t], a);
        coef_d[a][t] = td.coef;
        p01_d[a][t]  = pick(td.fsel[0], issue) * pick(td.fsel[1], issue);
        p23_d[a][t]  = pick(td.fsel[2], issue) * pick(td.fsel[3], issue);
      end
    end
    dg          = (issue.l == 3'd0) ? 3'd0 : issue.l - 3'd1;
    meta_d.l    = issue.l;
    meta_d.m    = issue.m;
    meta_d.last = issue.last;
    meta_d.sh_h = SH_W'(int'(issue.l) * int'(COORD_FRAC_BITS) + int'(KFRAC) - int'(OUT_FRAC));
    meta_d.sh_g = SH_W'(int'(dg) * int'(COORD_FRAC_BITS) + int'(KFRAC) - int'(OUT_FRAC));
  end

  // stage 6: round half up, shift to Q15.16 and saturate
  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      logic [SH_W-1:0]         s;
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] sum;
      logic signed [ACC_W-1:0] r;
      s    = (a == 0) ? m5_q.sh_h : m5_q.sh_g;
      half = ACC_W'(1) <<< (s - SH_W'(1));
      sum  = s5_acc_q[a] + half;
      r    = sum >>> s;
      if ((&r[ACC_W-1:31]) || !(|r[ACC_W-1:31])) begin
        res_d[a] = r[31:0];
      end else if (r[ACC_W-1]) begin
        res_d[a] = 32'sh8000_0000;
      end else begin
        res_d[a] = 32'sh7fff_ffff;
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= issue_valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // arithmetic stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= meta_d;
      m2_q   <= m1_q;
      m3_q   <= m2_q;
      m4_q   <= m3_q;
      m5_q   <= m4_q;
      s1_k_q <= k_d;
      for (int a = 0; a < NAXIS; a++) begin
        for (int t = 0; t < NTERM; t++) begin
          // stage 1
          s1_p01_q[a][t]  <= p01_d[a][t];
          s1_p23_q[a][t]  <= p23_d[a][t];
          s1_coef_q[a][t] <= coef_d[a][t];
          // stage 2: constant times second pair
          s2_pk_q[a][t]   <= 64'($signed({1'b0, s1_k_q}) * s1_p23_q[a][t]);
          s2_p01_q[a][t]  <= s1_p01_q[a][t];
          s2_coef_q[a][t] <= s1_coef_q[a][t];
          // stage 3: first pair times both halves
          s3_lo_q[a][t]   <= 64'(s2_p01_q[a][t] * $signed({1'b0, s2_pk_q[a][t][31:0]}));
          s3_hi_q[a][t]   <= 64'(s2_p01_q[a][t] * $signed(s2_pk_q[a][t][63:32]));
          s3_coef_q[a][t] <= s2_coef_q[a][t];
          // stage 4: join halves and apply the small coefficient
          s4_term_q[a][t] <= ACC_W'((PROD_W'(s3_hi_q[a][t]) <<< 32) + PROD_W'(s3_lo_q[a][t]))
                             * ACC_W'(s3_coef_q[a][t]);
        end
        // stage 5: sum the terms
        s5_acc_q[a] <= s4_term_q[a][0] + s4_term_q[a][1] + s4_term_q[a][2]
                     + s4_term_q[a][3] + s4_term_q[a][4] + s4_term_q[a][5];
      end
      out_q.degree_out <= m5_q.l;
      out_q.order_m    <= m5_q.m;
      out_q.last       <= m5_q.last;
      out_q.harmonic   <= res_d[0];
      out_q.grad_x     <= res_d[1];
      out_q.grad_y     <= res_d[2];
      out_q.grad_z     <= res_d[3];
    end
  end

  assign out_valid_o = v6_q;
  assign out_o       = out_q;

  // a degree 0 result has no gradient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.degree_out == 3'd0 |->
      out_o.grad_x == 32'sd0 && out_o.grad_y == 32'sd0 && out_o.grad_z == 32'sd0)
    else $error("nonzero gradient at degree 0");

  // order stays within its degree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.order_m <= $signed({1'b0, out_o.degree_out})
                 && out_o.order_m >= 4'sd0 - $signed({1'b0, out_o.degree_out}))
    else $error("order outside degree");

  // degree never exceeds the configured limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_o.degree_out) <= int'(MAX_DEGREE))
    else $error("degree above limit");

  // last closes the top order of its degree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last |-> out_o.order_m == $signed({1'b0, out_o.degree_out}))
    else $error("last on a result that is not the top order");

endmodule

/* hw/rtl/shg_seq.sv */
module shg_seq import shg_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  shg_in_t    in_i,
  output logic       issue_valid_o,
  input  logic       issue_take_i,
  output shg_issue_t issue_o
);

  logic               busy_q, busy_d;
  logic [2:0]         lim_q, lim_d;
  logic [2:0]         l_q, l_d;
  logic signed [3:0]  m_q, m_d;
  logic signed [15:0] x_q, y_q, z_q;
  logic               is_last;
  logic               accept;
  logic [2:0]         lim_in;
  logic [2:0]         l_start;

  // last (l, m) of the current item
  assign is_last    = (l_q == lim_q) && (m_q == $signed({1'b0, l_q}));
  assign in_ready_o = !busy_q || (issue_take_i && is_last);
  assign accept     = in_valid_i && in_ready_o;
  assign lim_in     = (int'(in_i.degree) > int'(MAX_DEGREE)) ? 3'(MAX_DEGREE) : in_i.degree;
  assign l_start    = in_i.cumulative ? 3'd0 : lim_in;

  // walk l and m, one result per cycle while the pipeline takes it
  always_comb begin
    busy_d = busy_q;
    lim_d  = lim_q;
    l_d    = l_q;
    m_d    = m_q;
    if (busy_q && issue_take_i) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else if (m_q == $signed({1'b0, l_q})) begin
        l_d = l_q + 3'd1;
        m_d = 4'sd0 - $signed({1'b0, l_q + 3'd1});
      end else begin
        m_d = m_q + 4'sd1;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      lim_d  = lim_in;
      l_d    = l_start;
      m_d    = 4'sd0 - $signed({1'b0, l_start});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lim_q  <= '0;
      l_q    <= '0;
      m_q    <= '0;
    end else begin
      busy_q <= busy_d;
      lim_q  <= lim_d;
      l_q    <= l_d;
      m_q    <= m_d;
    end
  end

  // coordinates of the item in progress
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= in_i.x_coord;
      y_q <= in_i.y_coord;
      z_q <= in_i.z_coord;
    end
  end

  assign issue_valid_o   = busy_q;
  assign issue_o.x_coord = x_q;
  assign issue_o.y_coord = y_q;
  assign issue_o.z_coord = z_q;
  assign issue_o.l       = l_q;
  assign issue_o.m       = m_q;
  assign issue_o.last    = is_last;

endmodule
